// ----- hw/rtl/lswc_pkg.sv -----
// Shared types, widths and constants for the line segment window clipper.
// Used by every module of the block; depends on nothing.
`default_nettype none

package lswc_pkg;

    // Coordinate width of the segment, the window and the clipped result.
    localparam int CoordBits = 16;
    // Width of one signed component of a clip parameter (numerator or denominator).
    localparam int ParamBits = CoordBits + 2;
    // Width of a cross product of two parameter components.
    localparam int CrossBits = 2 * ParamBits + 1;
    // Width of the interpolation numerator base*d + n*delta.
    localparam int NumBits   = CoordBits + ParamBits + 2;
    // Quotient bits produced by the divider, one per stage.
    localparam int QuotBits  = CoordBits + 1;
    // Depth of the queue between the front and back parts.
    localparam int QueueDepth = 2;
    localparam int QueuePtrBits = $clog2(QueueDepth);

    // Window reset values.
    localparam logic signed [CoordBits-1:0] WindowMinReset = CoordBits'(100);
    localparam logic signed [CoordBits-1:0] WindowMaxReset = CoordBits'(400);

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_LEFT   = 2'd0,
        REG_BOTTOM = 2'd1,
        REG_RIGHT  = 2'd2,
        REG_TOP    = 2'd3
    } t_cfg_idx;

    // One segment request.
    typedef struct packed {
        logic signed [CoordBits-1:0] start_x;
        logic signed [CoordBits-1:0] start_y;
        logic signed [CoordBits-1:0] end_x;
        logic signed [CoordBits-1:0] end_y;
    } t_seg_in;

    // One clipped result.
    typedef struct packed {
        logic signed [CoordBits-1:0] clipped_start_x;
        logic signed [CoordBits-1:0] clipped_start_y;
        logic signed [CoordBits-1:0] clipped_end_x;
        logic signed [CoordBits-1:0] clipped_end_y;
        logic                        visible;
    } t_seg_out;

    // Clip window held in configuration.
    typedef struct packed {
        logic signed [CoordBits-1:0] left;
        logic signed [CoordBits-1:0] bottom;
        logic signed [CoordBits-1:0] right;
        logic signed [CoordBits-1:0] top;
    } t_window;

    // A classified segment: endpoints, entry and exit fractions, visibility.
    typedef struct packed {
        logic signed [CoordBits-1:0] x0;
        logic signed [CoordBits-1:0] y0;
        logic signed [CoordBits-1:0] x1;
        logic signed [CoordBits-1:0] y1;
        logic signed [ParamBits-1:0] en;
        logic signed [ParamBits-1:0] ed;
        logic signed [ParamBits-1:0] xn;
        logic signed [ParamBits-1:0] xd;
        logic                        vis;
    } t_clip_job;

endpackage

`default_nettype wire

// ----- hw/rtl/lswc_front.sv -----
// Front part: registers a segment request and runs the four boundary tests
// (left, right, bottom, top), one pipeline stage per boundary. Uses lswc_pkg.
`default_nettype none

module lswc_front (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_accept,
    input  lswc_pkg::t_seg_in     i_seg,
    input  lswc_pkg::t_window     i_window,
    output logic                  o_valid,
    output lswc_pkg::t_clip_job   o_job
);
    import lswc_pkg::*;

    localparam int NumBnd = 4;

    logic                        r_vld [NumBnd+1];
    t_clip_job                   r_job [NumBnd+1];
    logic signed [ParamBits-1:0] r_p   [NumBnd+1][NumBnd];
    logic signed [ParamBits-1:0] r_q   [NumBnd+1][NumBnd];

    logic signed [CoordBits:0]   dx, dy;
    t_clip_job                   n_job [NumBnd];

    assign dx = (CoordBits+1)'(i_seg.end_x) - (CoordBits+1)'(i_seg.start_x);
    assign dy = (CoordBits+1)'(i_seg.end_y) - (CoordBits+1)'(i_seg.start_y);

    // Valid bits of every stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= NumBnd; s++) r_vld[s] <= 1'b0;
        end else begin
            r_vld[0] <= i_accept;
            for (int s = 0; s < NumBnd; s++) r_vld[s+1] <= r_vld[s];
        end
    end

    // Entry stage: boundary terms p and q, fractions at their start values.
    always_ff @(posedge i_clk) begin
        r_job[0].x0  <= i_seg.start_x;
        r_job[0].y0  <= i_seg.start_y;
        r_job[0].x1  <= i_seg.end_x;
        r_job[0].y1  <= i_seg.end_y;
        r_job[0].en  <= '0;
        r_job[0].ed  <= ParamBits'(1);
        r_job[0].xn  <= ParamBits'(1);
        r_job[0].xd  <= ParamBits'(1);
        r_job[0].vis <= 1'b1;
        r_p[0][0] <= -ParamBits'(dx);
        r_q[0][0] <= ParamBits'(i_seg.start_x) - ParamBits'(i_window.left);
        r_p[0][1] <= ParamBits'(dx);
        r_q[0][1] <= ParamBits'(i_window.right) - ParamBits'(i_seg.start_x);
        r_p[0][2] <= -ParamBits'(dy);
        r_q[0][2] <= ParamBits'(i_seg.start_y) - ParamBits'(i_window.bottom);
        r_p[0][3] <= ParamBits'(dy);
        r_q[0][3] <= ParamBits'(i_window.top) - ParamBits'(i_seg.start_y);
    end

    // One boundary per stage; fractions are compared by cross products.
    for (genvar k = 0; k < NumBnd; k++) begin : g_bnd
        logic signed [ParamBits-1:0] p, q, n, d;
        logic signed [CrossBits-1:0] cmp_en, cmp_ex;

        always_comb begin
            p = r_p[k][k];
            q = r_q[k][k];
            n = p[ParamBits-1] ? -q : q;
            d = p[ParamBits-1] ? -p : p;
            cmp_en = CrossBits'(n * r_job[k].ed) - CrossBits'(r_job[k].en * d);
            cmp_ex = CrossBits'(n * r_job[k].xd) - CrossBits'(r_job[k].xn * d);
            n_job[k] = r_job[k];
            if (p == '0) begin
                if (q[ParamBits-1]) n_job[k].vis = 1'b0;
            end else if (p[ParamBits-1]) begin
                // Entering edge: raise the entry fraction, reject past exit.
                if (!cmp_en[CrossBits-1] && cmp_en != '0) begin
                    n_job[k].en = n;
                    n_job[k].ed = d;
                end
                if (!cmp_ex[CrossBits-1] && cmp_ex != '0) n_job[k].vis = 1'b0;
            end else begin
                // Leaving edge: lower the exit fraction, reject before entry.
                if (cmp_ex[CrossBits-1]) begin
                    n_job[k].xn = n;
                    n_job[k].xd = d;
                end
                if (cmp_en[CrossBits-1]) n_job[k].vis = 1'b0;
            end
        end

        always_ff @(posedge i_clk) begin
            r_job[k+1] <= n_job[k];
            for (int j = 0; j < NumBnd; j++) begin
                r_p[k+1][j] <= r_p[k][j];
                r_q[k+1][j] <= r_q[k][j];
            end
        end
    end

    assign o_valid = r_vld[NumBnd];
    assign o_job   = r_job[NumBnd];

endmodule

`default_nettype wire

// ----- hw/rtl/lswc_queue.sv -----
// Short queue between the front and back parts of the clipper.
// Uses lswc_pkg for the job type and depth.
`default_nettype none

module lswc_queue (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_push,
    input  lswc_pkg::t_clip_job   i_job,
    input  wire                   i_pop,
    output logic                  o_empty,
    output logic                  o_full,
    output lswc_pkg::t_clip_job   o_job
);
    import lswc_pkg::*;

    t_clip_job                r_mem [QueueDepth];
    logic [QueuePtrBits-1:0]  r_wp, r_rp;
    logic [QueuePtrBits:0]    r_cnt;
    logic                     do_push, do_pop;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == (QueuePtrBits+1)'(QueueDepth));
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_job   = r_mem[r_rp];

    // Storage.
    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_job;
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= QueuePtrBits'((r_wp + 1'b1) % QueueDepth);
            if (do_pop)  r_rp <= QueuePtrBits'((r_rp + 1'b1) % QueueDepth);
            r_cnt <= r_cnt + (QueuePtrBits+1)'(do_push) - (QueuePtrBits+1)'(do_pop);
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/lswc_div.sv -----
// Pipelined restoring divider lane: one quotient bit per stage, magnitude
// and sign in, truncated signed quotient out. Uses lswc_pkg widths.
`default_nettype none

module lswc_div (
    input  wire                          i_clk,
    input  wire  [lswc_pkg::NumBits-1:0]   i_mag,
    input  wire                          i_neg,
    input  wire  [lswc_pkg::ParamBits-1:0] i_div,
    output logic signed [lswc_pkg::CoordBits-1:0] o_quot
);
    import lswc_pkg::*;

    logic [ParamBits-1:0] r_rem [QuotBits+1];
    logic [QuotBits-1:0]  r_low [QuotBits+1];
    logic [QuotBits-1:0]  r_q   [QuotBits+1];
    logic [ParamBits-1:0] r_d   [QuotBits+1];
    logic                 r_neg [QuotBits+1];

    // Load: the high part of the dividend is already below the divisor.
    always_ff @(posedge i_clk) begin
        r_rem[0] <= i_mag[QuotBits +: ParamBits];
        r_low[0] <= i_mag[QuotBits-1:0];
        r_q[0]   <= '0;
        r_d[0]   <= i_div;
        r_neg[0] <= i_neg;
    end

    for (genvar s = 0; s < QuotBits; s++) begin : g_step
        logic [ParamBits:0] trial, diff;
        always_comb begin
            trial = {r_rem[s], r_low[s][QuotBits-1]};
            diff  = trial - {1'b0, r_d[s]};
        end
        always_ff @(posedge i_clk) begin
            r_rem[s+1] <= diff[ParamBits] ? trial[ParamBits-1:0] : diff[ParamBits-1:0];
            r_q[s+1]   <= {r_q[s][QuotBits-2:0], ~diff[ParamBits]};
            r_low[s+1] <= {r_low[s][QuotBits-2:0], 1'b0};
            r_d[s+1]   <= r_d[s];
            r_neg[s+1] <= r_neg[s];
        end
    end

    // Apply the sign and keep the coordinate bits.
    always_comb begin
        o_quot = r_neg[QuotBits] ? -CoordBits'(r_q[QuotBits]) : CoordBits'(r_q[QuotBits]);
    end

endmodule

`default_nettype wire

// ----- hw/rtl/lswc_back.sv -----
// Back part: interpolates the clipped endpoints, x0 + (n/d)*dx in four
// divider lanes, and registers the result. Uses lswc_pkg and lswc_div.
`default_nettype none

module lswc_back (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_valid,
    input  lswc_pkg::t_clip_job   i_job,
    output logic                  o_done,
    output lswc_pkg::t_seg_out    o_result
);
    import lswc_pkg::*;

    localparam int NumLanes = 4;
    // Side-band delay covers the product, magnitude and divider stages.
    localparam int SideDepth = QuotBits + 3;

    typedef struct packed {
        logic                        vld;
        logic                        vis;
        logic                        cut_start;
        logic                        cut_end;
        logic signed [CoordBits-1:0] x0;
        logic signed [CoordBits-1:0] y0;
        logic signed [CoordBits-1:0] x1;
        logic signed [CoordBits-1:0] y1;
    } t_side;

    t_side                          r_side [SideDepth];
    t_side                          n_side;
    logic signed [CoordBits-1:0]    base  [NumLanes];
    logic signed [CoordBits:0]      delta [NumLanes];
    logic signed [ParamBits-1:0]    num   [NumLanes];
    logic signed [ParamBits-1:0]    den   [NumLanes];
    logic signed [NumBits-1:0]      r_pa  [NumLanes];
    logic signed [NumBits-1:0]      r_pb  [NumLanes];
    logic [ParamBits-1:0]           r_d0  [NumLanes];
    logic [NumBits-1:0]             r_mag [NumLanes];
    logic                           r_neg [NumLanes];
    logic [ParamBits-1:0]           r_d1  [NumLanes];
    logic signed [CoordBits-1:0]    quot  [NumLanes];
    logic                           r_done;
    t_seg_out                       r_result;
    t_side                          last;

    // Lanes: end x, end y at the exit fraction; start x, start y at entry.
    always_comb begin
        base[0]  = i_job.x0;  delta[0] = (CoordBits+1)'(i_job.x1) - (CoordBits+1)'(i_job.x0);
        base[1]  = i_job.y0;  delta[1] = (CoordBits+1)'(i_job.y1) - (CoordBits+1)'(i_job.y0);
        base[2]  = i_job.x0;  delta[2] = delta[0];
        base[3]  = i_job.y0;  delta[3] = delta[1];
        num[0] = i_job.xn; den[0] = i_job.xd;
        num[1] = i_job.xn; den[1] = i_job.xd;
        num[2] = i_job.en; den[2] = i_job.ed;
        num[3] = i_job.en; den[3] = i_job.ed;
        n_side.vld       = i_valid;
        n_side.vis       = i_job.vis;
        n_side.cut_end   = (i_job.xn < i_job.xd);
        n_side.cut_start = !i_job.en[ParamBits-1] && (i_job.en != '0);
        n_side.x0 = i_job.x0;
        n_side.y0 = i_job.y0;
        n_side.x1 = i_job.x1;
        n_side.y1 = i_job.y1;
    end

    for (genvar l = 0; l < NumLanes; l++) begin : g_lane
        logic signed [NumBits-1:0] sum;

        // Products, then their sum as sign and magnitude.
        always_ff @(posedge i_clk) begin
            r_pa[l] <= NumBits'(base[l] * den[l]);
            r_pb[l] <= NumBits'(num[l] * delta[l]);
            r_d0[l] <= den[l];
        end

        assign sum = r_pa[l] + r_pb[l];

        always_ff @(posedge i_clk) begin
            r_neg[l] <= sum[NumBits-1];
            r_mag[l] <= sum[NumBits-1] ? NumBits'(-sum) : NumBits'(sum);
            r_d1[l]  <= r_d0[l];
        end

        lswc_div u_div (
            .i_clk  (i_clk),
            .i_mag  (r_mag[l]),
            .i_neg  (r_neg[l]),
            .i_div  (r_d1[l]),
            .o_quot (quot[l])
        );
    end

    // Side-band delay line; cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < SideDepth; s++) r_side[s] <= '0;
        end else begin
            r_side[0] <= n_side;
            for (int s = 1; s < SideDepth; s++) r_side[s] <= r_side[s-1];
        end
    end

    assign last = r_side[SideDepth-1];

    // Result register: pass-through, interpolated or zero when rejected.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= last.vld;
        end
        r_result.visible <= last.vis;
        if (!last.vis) begin
            r_result.clipped_start_x <= '0;
            r_result.clipped_start_y <= '0;
            r_result.clipped_end_x   <= '0;
            r_result.clipped_end_y   <= '0;
        end else begin
            r_result.clipped_end_x   <= last.cut_end   ? quot[0] : last.x1;
            r_result.clipped_end_y   <= last.cut_end   ? quot[1] : last.y1;
            r_result.clipped_start_x <= last.cut_start ? quot[2] : last.x0;
            r_result.clipped_start_y <= last.cut_start ? quot[3] : last.y0;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

`default_nettype wire

// ----- hw/rtl/line_segment_window_clipper_unit.sv -----
// Top level of the line segment window clipper: window registers, front
// classifier, queue and back interpolator. Uses lswc_pkg and its submodules.
//
// The clipper takes one segment request in every clock cycle and returns one
// result per request, in order, on o_result for exactly one cycle marked by
// o_done; the receiver cannot stall it. From the accepting edge a request
// passes through the input register, the boundary stages, the queue, the
// product and magnitude registers that form the interpolation numerator, the
// divider lanes (a load stage plus 17 bit stages) and the result register.
// busy stays low in use, since the back part drains the queue every cycle.
// The window may be rewritten only when no request is in flight.
`default_nettype none

module line_segment_window_clipper_unit (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               start,
    output logic                              busy,
    input  lswc_pkg::t_seg_in                 i_seg,
    input  wire                               i_cfg_we,
    input  wire  [1:0]                        i_cfg_idx,
    input  wire  [lswc_pkg::CoordBits-1:0]    i_cfg_data,
    output logic                              o_done,
    output lswc_pkg::t_seg_out                o_result
);
    import lswc_pkg::*;

    t_window    r_window;
    logic       accept;
    logic       front_vld;
    t_clip_job  front_job;
    logic       q_empty, q_full;
    t_clip_job  q_job;

    assign accept = start && !busy;
    assign busy   = q_full;

    // Window registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window.left   <= WindowMinReset;
            r_window.bottom <= WindowMinReset;
            r_window.right  <= WindowMaxReset;
            r_window.top    <= WindowMaxReset;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                REG_LEFT:   r_window.left   <= i_cfg_data;
                REG_BOTTOM: r_window.bottom <= i_cfg_data;
                REG_RIGHT:  r_window.right  <= i_cfg_data;
                REG_TOP:    r_window.top    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    lswc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_seg    (i_seg),
        .i_window (r_window),
        .o_valid  (front_vld),
        .o_job    (front_job)
    );

    lswc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_vld),
        .i_job   (front_job),
        .i_pop   (1'b1),
        .o_empty (q_empty),
        .o_full  (q_full),
        .o_job   (q_job)
    );

    lswc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (!q_empty),
        .i_job    (q_job),
        .o_done   (o_done),
        .o_result (o_result)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/lswc_checker.sv -----
// Port-level checks for the line segment window clipper, bound to the top
// level. Uses lswc_pkg types for the ports it watches.
`default_nettype none

module lswc_checker (
    input wire                  i_clk,
    input wire                  i_rst_n,
    input wire                  start,
    input wire                  busy,
    input wire                  o_done,
    input lswc_pkg::t_seg_out   o_result
);
    // Reset empties the pipeline, so no result follows a reset cycle.
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_done)
        else $error("result strobe right after reset");

    // A rejected segment reports all coordinates as zero.
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_result.visible) |->
        (o_result.clipped_start_x == '0 && o_result.clipped_start_y == '0 &&
         o_result.clipped_end_x == '0 && o_result.clipped_end_y == '0))
        else $error("rejected segment with nonzero coordinates");

    // The back part drains every cycle, so the block never holds requests off.
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> !busy)
        else $error("request refused while the queue should drain");

endmodule

bind line_segment_window_clipper_unit lswc_checker u_lswc_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_done   (o_done),
    .o_result (o_result)
);

`default_nettype wire
